// ===== rtl/core/bec_pkg.sv =====
// Types, character constants and lookup functions shared by the escape codec.
`timescale 1ns / 1ps

package bec_pkg;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;

  localparam logic MODE_ESCAPE   = 1'b0;
  localparam logic MODE_UNESCAPE = 1'b1;

  // Number of results one input item produces.
  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2
  } res_cnt_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_last;
  } res_t;

  // Decoded outcome of one input item.
  typedef struct packed {
    res_cnt_t cnt;
    res_t     first;
    res_t     second;
    logic     pending_nxt;
  } conv_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
  } lookup_t;

  function automatic lookup_t escape_letter(input logic [7:0] b);
    lookup_t r;
    r.hit = 1'b1;
    case (b)
      CH_NL:    r.ch = CH_N;
      CH_TAB:   r.ch = CH_T;
      CH_CR:    r.ch = CH_R;
      CH_QUOTE: r.ch = CH_QUOTE;
      CH_BSL:   r.ch = CH_BSL;
      default: begin
        r.hit = 1'b0;
        r.ch  = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic lookup_t unescape_letter(input logic [7:0] b);
    lookup_t r;
    r.hit = 1'b1;
    case (b)
      CH_N:     r.ch = CH_NL;
      CH_T:     r.ch = CH_TAB;
      CH_R:     r.ch = CH_CR;
      CH_QUOTE: r.ch = CH_QUOTE;
      CH_BSL:   r.ch = CH_BSL;
      default: begin
        r.hit = 1'b0;
        r.ch  = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/bec_in_if.sv =====
// Input channel of the escape codec: one string byte per item.
`timescale 1ns / 1ps

interface bec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/bec_out_if.sv =====
// Result channel of the escape codec: one converted byte per item.
`timescale 1ns / 1ps

interface bec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_last;

  modport source (output valid, output out_byte, output run_last, output string_last,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input string_last,
                output ready);
endinterface

// ===== rtl/core/backslash_escape_codec.sv =====
// Top level of the streaming backslash escape / unescape codec.
//
//   port     dir   handshake     payload
//   in_ch    in    valid/ready   in_byte[7:0], last_byte
//   out_ch   out   valid/ready   out_byte[7:0], run_last, string_last
//   cfg_*    in    cfg_we        cfg_wdata = mode
//
// An item moves into an input register, is decoded there, and its results
// load the output register and a second-result register. The output register's
// single port sends one result at a time, so an item with two results keeps the
// next item waiting until its second result is out; a held backslash yields no
// result. Reset is synchronous and clears mode and the held backslash; a stalled
// output holds its item while the input register still takes one more item.
`timescale 1ns / 1ps

module backslash_escape_codec (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  bec_in_if.sink    in_ch,
  bec_out_if.source out_ch
);

  logic           mode_r;
  logic           pending_r;
  logic           in_v_r;
  logic [7:0]     in_byte_r;
  logic           in_last_r;
  logic           out_v_r;
  bec_pkg::res_t  out_r;
  logic           sec_v_r;
  bec_pkg::res_t  sec_r;

  bec_pkg::conv_t conv;
  logic           out_free;
  logic           adv;

  bec_conv u_conv (
    .mode      (mode_r),
    .pending   (pending_r),
    .in_byte   (in_byte_r),
    .last_byte (in_last_r),
    .conv      (conv)
  );

  assign out_free = !out_v_r || out_ch.ready;
  // The held item leaves once its results have room; one with no result always can.
  assign adv = in_v_r && (conv.cnt == bec_pkg::CNT_NONE || (!sec_v_r && out_free));

  assign in_ch.ready        = !in_v_r || adv;
  assign out_ch.valid       = out_v_r;
  assign out_ch.out_byte    = out_r.out_byte;
  assign out_ch.run_last    = out_r.run_last;
  assign out_ch.string_last = out_r.string_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= bec_pkg::MODE_ESCAPE;
      pending_r <= 1'b0;
      in_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      sec_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r    <= cfg_wdata;
        pending_r <= 1'b0;
      end else if (adv) begin
        pending_r <= conv.pending_nxt;
      end

      if (in_ch.valid && in_ch.ready) begin
        in_v_r    <= 1'b1;
        in_byte_r <= in_ch.in_byte;
        in_last_r <= in_ch.last_byte;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end

      if (out_free) begin
        if (sec_v_r) begin
          out_v_r <= 1'b1;
          out_r   <= sec_r;
          sec_v_r <= 1'b0;
        end else if (adv && conv.cnt != bec_pkg::CNT_NONE) begin
          out_v_r <= 1'b1;
          out_r   <= conv.first;
          sec_v_r <= (conv.cnt == bec_pkg::CNT_TWO);
          sec_r   <= conv.second;
        end else begin
          out_v_r <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTH
  a_sec_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sec_v_r |-> out_v_r)
    else $error("second result held without a first result");

  a_first_not_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    sec_v_r |-> (!out_r.run_last && sec_r.run_last))
    else $error("run end flags out of order within a two-result item");

  a_escape_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && mode_r == bec_pkg::MODE_ESCAPE) |=> !pending_r)
    else $error("backslash held in escape mode");

  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !in_ch.ready) |=> in_v_r)
    else $error("stalled input item lost");
`endif

endmodule

// ===== rtl/core/bec_conv.sv =====
// Combinational conversion of one held byte into zero, one or two result bytes.
`timescale 1ns / 1ps

module bec_conv (
  input  logic           mode,
  input  logic           pending,
  input  logic [7:0]     in_byte,
  input  logic           last_byte,
  output bec_pkg::conv_t conv
);

  bec_pkg::lookup_t esc;
  bec_pkg::lookup_t unesc;

  assign esc   = bec_pkg::escape_letter(in_byte);
  assign unesc = bec_pkg::unescape_letter(in_byte);

  always_comb begin
    conv.cnt         = bec_pkg::CNT_ONE;
    conv.first       = '{out_byte: in_byte, run_last: 1'b1, string_last: last_byte};
    conv.second      = '{out_byte: in_byte, run_last: 1'b1, string_last: last_byte};
    conv.pending_nxt = 1'b0;
    if (mode == bec_pkg::MODE_ESCAPE) begin
      if (esc.hit) begin
        conv.cnt          = bec_pkg::CNT_TWO;
        conv.first        = '{out_byte: bec_pkg::CH_BSL, run_last: 1'b0, string_last: 1'b0};
        conv.second.out_byte = esc.ch;
      end
    end else if (pending) begin
      if (unesc.hit) begin
        conv.first.out_byte = unesc.ch;
      end else begin
        // Unknown escape: the held backslash comes out ahead of the byte.
        conv.cnt   = bec_pkg::CNT_TWO;
        conv.first = '{out_byte: bec_pkg::CH_BSL, run_last: 1'b0, string_last: 1'b0};
      end
    end else if (in_byte == bec_pkg::CH_BSL && !last_byte) begin
      conv.cnt         = bec_pkg::CNT_NONE;
      conv.pending_nxt = 1'b1;
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the backslash escape codec, with random strings in both modes.
`timescale 1ns / 1ps

module testbench;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  // Mirrors the codec: mode, the held backslash and the result bytes still due.
  class escape_tracker;
    bec_pkg::res_t due_bytes[$];
    logic mode;
    logic held_bsl;
    int bad_bytes;
    int bytes_in;
    int bytes_out;
    int held_count;

    function new();
      mode = bec_pkg::MODE_ESCAPE;
      held_bsl = 1'b0;
      bad_bytes = 0;
      bytes_in = 0;
      bytes_out = 0;
      held_count = 0;
    endfunction

    function void set_mode(logic m);
      mode = m;
      held_bsl = 1'b0;
    endfunction

    function void queue_byte(logic [7:0] b, logic run_end, logic str_end);
      bec_pkg::res_t r;
      r.out_byte = b;
      r.run_last = run_end;
      r.string_last = str_end;
      due_bytes.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      logic [7:0] code;
      logic known;
      bytes_in++;
      code = b;
      known = 1'b1;
      if (mode == bec_pkg::MODE_ESCAPE) begin
        held_bsl = 1'b0;
        case (b)
          bec_pkg::CH_NL:    code = bec_pkg::CH_N;
          bec_pkg::CH_TAB:   code = bec_pkg::CH_T;
          bec_pkg::CH_CR:    code = bec_pkg::CH_R;
          bec_pkg::CH_QUOTE: code = bec_pkg::CH_QUOTE;
          bec_pkg::CH_BSL:   code = bec_pkg::CH_BSL;
          default:           known = 1'b0;
        endcase
        if (known) begin
          queue_byte(bec_pkg::CH_BSL, 1'b0, 1'b0);
          queue_byte(code, 1'b1, last);
        end else begin
          queue_byte(b, 1'b1, last);
        end
      end else if (held_bsl) begin
        held_bsl = 1'b0;
        case (b)
          bec_pkg::CH_N:     code = bec_pkg::CH_NL;
          bec_pkg::CH_T:     code = bec_pkg::CH_TAB;
          bec_pkg::CH_R:     code = bec_pkg::CH_CR;
          bec_pkg::CH_QUOTE: code = bec_pkg::CH_QUOTE;
          bec_pkg::CH_BSL:   code = bec_pkg::CH_BSL;
          default:           known = 1'b0;
        endcase
        if (known) begin
          queue_byte(code, 1'b1, last);
        end else begin
          // An unknown escape gives back the backslash and the byte as they came.
          queue_byte(bec_pkg::CH_BSL, 1'b0, 1'b0);
          queue_byte(b, 1'b1, last);
        end
      end else if (b == bec_pkg::CH_BSL && !last) begin
        held_bsl = 1'b1;
        held_count++;
      end else begin
        queue_byte(b, 1'b1, last);
      end
    endfunction

    function void flag(string what, bec_pkg::res_t want, bec_pkg::res_t got);
      bad_bytes++;
      if (bad_bytes <= 10) begin
        $display("%0t: %s: expected byte %02h run_last %b string_last %b,",
                 $time, what, want.out_byte, want.run_last, want.string_last);
        $display("  got byte %02h run_last %b string_last %b",
                 got.out_byte, got.run_last, got.string_last);
      end
    endfunction

    function void match_byte(bec_pkg::res_t got);
      bec_pkg::res_t want;
      bytes_out++;
      if (due_bytes.size() == 0) begin
        want = '0;
        flag("result with nothing due", want, got);
      end else begin
        want = due_bytes.pop_front();
        if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
            got.string_last !== want.string_last) begin
          flag("mismatch", want, got);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  logic sender_gaps;
  logic receiver_stalls;
  logic hold_now;
  int mode_writes;
  escape_tracker tracker;

  bec_in_if in_ch ();
  bec_out_if out_ch ();

  backslash_escape_codec u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      tracker.take_byte(in_ch.in_byte, in_ch.last_byte);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.match_byte({out_ch.out_byte, out_ch.run_last, out_ch.string_last});
    end
  end

  // Result side: random stalls, or one long hold-off on request.
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_now && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= !receiver_stalls || ($urandom_range(99) >= 16);
        @(posedge clk);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Timed out after %0d cycles without a transfer.", IDLE_LIMIT);
    $display("testbench failed");
    $finish;
  end

  task automatic send_item(input logic [7:0] b, input logic last);
    if (sender_gaps && $urandom_range(99) < 16) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops offering items and waits until every due result has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    // Let the clock advance first, so the last accepted item is already in the tracker.
    @(posedge clk);
    while (tracker.due_bytes.size() != 0) @(posedge clk);
    // A held backslash produces nothing, so give the pipeline time to settle.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_mode(m);
    mode_writes++;
  endtask

  function automatic logic [7:0] pick_byte(input logic after_bsl);
    int roll;
    logic [7:0] b;
    roll = $urandom_range(99);
    b = 8'($urandom_range(255));
    if (after_bsl && roll < 70) begin
      case ($urandom_range(4))
        0: b = bec_pkg::CH_N;
        1: b = bec_pkg::CH_T;
        2: b = bec_pkg::CH_R;
        3: b = bec_pkg::CH_QUOTE;
        default: b = bec_pkg::CH_BSL;
      endcase
    end else if (roll < 15) begin
      b = bec_pkg::CH_BSL;
    end else if (roll < 30) begin
      case ($urandom_range(6))
        0: b = bec_pkg::CH_NL;
        1: b = bec_pkg::CH_TAB;
        2: b = bec_pkg::CH_CR;
        3: b = bec_pkg::CH_QUOTE;
        4: b = bec_pkg::CH_N;
        5: b = bec_pkg::CH_T;
        default: b = bec_pkg::CH_R;
      endcase
    end
    return b;
  endfunction

  task automatic send_string(input int len);
    logic [7:0] b;
    logic after_bsl;
    after_bsl = 1'b0;
    for (int i = 0; i < len; i++) begin
      b = pick_byte(after_bsl);
      send_item(b, i == len - 1);
      after_bsl = (b == bec_pkg::CH_BSL) && !after_bsl;
    end
  endtask

  initial begin
    int sent;
    int len;
    int waited;
    logic phase_mode;
    tracker = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    hold_now = 1'b0;
    mode_writes = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Escape mode straight out of reset.
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(bec_pkg::CH_NL, 1'b0);
    send_item(bec_pkg::CH_TAB, 1'b0);
    send_item(bec_pkg::CH_CR, 1'b0);
    send_item(bec_pkg::CH_QUOTE, 1'b0);
    send_item(bec_pkg::CH_BSL, 1'b1);
    drain();

    // Every known escape, an escaped backslash, unknown escapes and a trailing backslash.
    write_mode(bec_pkg::MODE_UNESCAPE);
    send_item(bec_pkg::CH_BSL, 1'b0);
    send_item(bec_pkg::CH_N, 1'b0);
    send_item(bec_pkg::CH_BSL, 1'b0);
    send_item(bec_pkg::CH_T, 1'b0);
    send_item(bec_pkg::CH_BSL, 1'b0);
    send_item(bec_pkg::CH_R, 1'b0);
    send_item(bec_pkg::CH_BSL, 1'b0);
    send_item(bec_pkg::CH_QUOTE, 1'b0);
    send_item(bec_pkg::CH_BSL, 1'b0);
    send_item(bec_pkg::CH_BSL, 1'b0);
    send_item(bec_pkg::CH_BSL, 1'b0);
    send_item(8'h41, 1'b0);
    send_item(bec_pkg::CH_BSL, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(bec_pkg::CH_BSL, 1'b1);

    // A mode write drops a held backslash, in either mode.
    send_item(bec_pkg::CH_BSL, 1'b0);
    drain();
    write_mode(bec_pkg::MODE_UNESCAPE);
    send_item(bec_pkg::CH_N, 1'b1);
    send_item(bec_pkg::CH_BSL, 1'b0);
    drain();
    write_mode(bec_pkg::MODE_ESCAPE);
    send_item(bec_pkg::CH_N, 1'b1);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      phase_mode = (ph % 3 == 0) ? logic'($urandom_range(1)) : logic'(ph % 2);
      write_mode(phase_mode);
      sender_gaps = (ph != 4);
      receiver_stalls = (ph != 4);
      if (ph == 6) begin
        hold_now = 1'b1;
      end
      sent = 0;
      while (sent < 140) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        send_string(len);
        sent += len;
      end
      drain();
    end

    waited = 0;
    while (tracker.due_bytes.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);

    $display("Sent %0d string bytes and checked %0d result bytes across %0d mode writes,",
             tracker.bytes_in, tracker.bytes_out, mode_writes);
    $display("with %0d backslashes held in unescape mode and a long output hold-off.",
             tracker.held_count);
    if (tracker.due_bytes.size() != 0) begin
      $display("%0d result bytes never arrived.", tracker.due_bytes.size());
    end
    if (tracker.bad_bytes == 0 && tracker.due_bytes.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
